// ===== design/tfp_pkg.sv =====
// ----------------------------------------------------------------------------
// Telemetry frame parser package
// Shared types, constants and the CRC-8 update used by the frame parser.
// ----------------------------------------------------------------------------
package tfp_pkg;

    localparam logic [7:0]  CRC_POLY = 8'h07;
    localparam logic [8:0]  MIN_LEN  = 9'd8;
    localparam logic [15:0] MAX_LEN  = 16'd263;

    typedef enum logic [1:0] {
        REG_SYNC_VALUE     = 2'd0,
        REG_TYPE_MASK      = 2'd1,
        REG_TYPE_VERSION   = 2'd2,
        REG_SEED_WITH_SYNC = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_PAYLOAD  = 2'd1,
        EV_ACCEPT   = 2'd2,
        EV_MISMATCH = 2'd3
    } event_t;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_TYPE = 3'd1,
        PH_LEN  = 3'd2,
        PH_OBJ  = 3'd3,
        PH_DATA = 3'd4,
        PH_CRC  = 3'd5
    } phase_t;

    typedef struct packed {
        logic [7:0] sync_value;
        logic [7:0] type_mask;
        logic [7:0] type_version;
        logic       seed_with_sync;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic [7:0]  msg_type;
        logic [31:0] object_id;
        logic [8:0]  frame_length;
        logic [7:0]  computed_crc;
    } result_t;

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] v;
        v = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            if (v[7]) begin
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

// ===== design/tfp_parser.sv =====
// ----------------------------------------------------------------------------
// Telemetry frame parser state machine
// Holds the frame state and works out the result of one byte in one pass.
// ----------------------------------------------------------------------------
module tfp_parser (
    input  logic             aclk,
    input  logic             aresetn,
    input  tfp_pkg::cfg_t    cfg,
    input  logic             byte_load,
    input  logic [7:0]       in_byte,
    output tfp_pkg::result_t res
);

    tfp_pkg::phase_t phase_reg, phase_next;
    logic [7:0]      crc_reg, crc_next;
    logic [7:0]      cnt_reg, cnt_next;
    logic [7:0]      type_reg, type_next;
    logic [31:0]     obj_reg, obj_next;
    logic [8:0]      len_reg, len_next;
    logic [15:0]     len_full;
    logic [7:0]      cnt_inc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= tfp_pkg::PH_HUNT;
            crc_reg   <= '0;
            cnt_reg   <= '0;
            type_reg  <= '0;
            obj_reg   <= '0;
            len_reg   <= '0;
        end else if (byte_load) begin
            phase_reg <= phase_next;
            crc_reg   <= crc_next;
            cnt_reg   <= cnt_next;
            type_reg  <= type_next;
            obj_reg   <= obj_next;
            len_reg   <= len_next;
        end
    end

    always_comb begin
        phase_next        = phase_reg;
        crc_next          = crc_reg;
        cnt_next          = cnt_reg;
        type_next         = type_reg;
        obj_next          = obj_reg;
        len_next          = len_reg;
        len_full          = {in_byte, len_reg[7:0]};
        cnt_inc           = cnt_reg + 8'd1;
        res.event_res     = tfp_pkg::EV_NONE;
        res.payload_byte  = '0;
        res.payload_index = '0;
        res.frame_length  = '0;
        unique case (phase_reg)
            tfp_pkg::PH_TYPE: begin
                crc_next = tfp_pkg::crc8_step(crc_reg, in_byte);
                if ((in_byte & cfg.type_mask) == cfg.type_version) begin
                    type_next  = in_byte;
                    cnt_next   = '0;
                    phase_next = tfp_pkg::PH_LEN;
                end else begin
                    phase_next = tfp_pkg::PH_HUNT;
                end
            end
            tfp_pkg::PH_LEN: begin
                crc_next = tfp_pkg::crc8_step(crc_reg, in_byte);
                if (cnt_reg == 8'd0) begin
                    len_next = {1'b0, in_byte};
                    cnt_next = 8'd1;
                end else begin
                    len_next = {in_byte[0], len_reg[7:0]};
                    cnt_next = '0;
                    if (len_full < 16'(tfp_pkg::MIN_LEN) || len_full > tfp_pkg::MAX_LEN) begin
                        phase_next = tfp_pkg::PH_HUNT;
                    end else begin
                        phase_next = tfp_pkg::PH_OBJ;
                    end
                end
            end
            tfp_pkg::PH_OBJ: begin
                crc_next = tfp_pkg::crc8_step(crc_reg, in_byte);
                obj_next[{cnt_reg[1:0], 3'b000} +: 8] = in_byte;
                if (cnt_reg[1:0] == 2'd3) begin
                    cnt_next   = '0;
                    phase_next = (len_reg == tfp_pkg::MIN_LEN) ? tfp_pkg::PH_CRC
                                                                : tfp_pkg::PH_DATA;
                end else begin
                    cnt_next = cnt_inc;
                end
            end
            tfp_pkg::PH_DATA: begin
                crc_next          = tfp_pkg::crc8_step(crc_reg, in_byte);
                res.event_res     = tfp_pkg::EV_PAYLOAD;
                res.payload_byte  = in_byte;
                res.payload_index = cnt_reg;
                if (cnt_inc == 8'd0 || {1'b0, cnt_inc} >= (len_reg - tfp_pkg::MIN_LEN)) begin
                    cnt_next   = '0;
                    phase_next = tfp_pkg::PH_CRC;
                end else begin
                    cnt_next = cnt_inc;
                end
            end
            tfp_pkg::PH_CRC: begin
                res.frame_length = len_reg;
                res.event_res    = (in_byte == crc_reg) ? tfp_pkg::EV_ACCEPT
                                                        : tfp_pkg::EV_MISMATCH;
                phase_next       = tfp_pkg::PH_HUNT;
            end
            default: begin
                phase_next = tfp_pkg::PH_HUNT;
                if (in_byte == cfg.sync_value) begin
                    crc_next   = cfg.seed_with_sync ? tfp_pkg::crc8_step(8'h00, in_byte)
                                                    : 8'h00;
                    phase_next = tfp_pkg::PH_TYPE;
                end
            end
        endcase
        res.msg_type     = type_next;
        res.object_id    = obj_next;
        res.computed_crc = crc_next;
    end

endmodule

// ===== design/tfp_out_stage.sv =====
// ----------------------------------------------------------------------------
// Telemetry frame parser result register
// Holds one result until the downstream side takes the transfer.
// ----------------------------------------------------------------------------
module tfp_out_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  tfp_pkg::result_t res_in,
    input  logic             m_ready,
    output logic             m_valid,
    output logic             can_load,
    output tfp_pkg::result_t res_out
);

    logic             valid_reg, valid_next;
    tfp_pkg::result_t res_reg;

    assign can_load   = !valid_reg || m_ready;
    assign valid_next = load || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_in;
        end
    end

    assign m_valid = valid_reg;
    assign res_out = res_reg;

endmodule

// ===== design/telemetry_frame_parser_crc8.sv =====
// ----------------------------------------------------------------------------
// Telemetry frame parser with CRC-8 check
// Deframes telemetry packets from a byte stream and checks their CRC-8.
// ----------------------------------------------------------------------------
// The parser takes one byte per cycle unless stalled and gives exactly one
// result per byte, in the cycle after the byte's transfer. The CRC update
// and the frame state change are done in a single registered pass. The result
// register lets the next byte in during any cycle in which it is empty or
// its result is taken, so the sustained rate is one byte per cycle as long as
// the result side keeps taking transfers; while a result waits, the byte side
// stalls. Configuration writes take effect from the next byte.
module telemetry_frame_parser_crc8 (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_event_res,
    output logic [7:0]  m_payload_byte,
    output logic [7:0]  m_payload_index,
    output logic [7:0]  m_msg_type,
    output logic [31:0] m_object_id,
    output logic [8:0]  m_frame_length,
    output logic [7:0]  m_computed_crc
);

    tfp_pkg::cfg_t    cfg_reg;
    tfp_pkg::result_t res_next;
    tfp_pkg::result_t res_out;
    logic             byte_load;
    logic             can_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_value     <= 8'd60;
            cfg_reg.type_mask      <= 8'd120;
            cfg_reg.type_version   <= 8'd32;
            cfg_reg.seed_with_sync <= 1'b1;
        end else if (cfg_we) begin
            unique case (tfp_pkg::reg_index_t'(cfg_index))
                tfp_pkg::REG_SYNC_VALUE:     cfg_reg.sync_value     <= cfg_wdata;
                tfp_pkg::REG_TYPE_MASK:      cfg_reg.type_mask      <= cfg_wdata;
                tfp_pkg::REG_TYPE_VERSION:   cfg_reg.type_version   <= cfg_wdata;
                tfp_pkg::REG_SEED_WITH_SYNC: cfg_reg.seed_with_sync <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign s_ready   = can_load;
    assign byte_load = s_valid && can_load;

    tfp_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .byte_load (byte_load),
        .in_byte   (s_in_byte),
        .res       (res_next)
    );

    tfp_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (byte_load),
        .res_in   (res_next),
        .m_ready  (m_ready),
        .m_valid  (m_valid),
        .can_load (can_load),
        .res_out  (res_out)
    );

    assign m_event_res     = res_out.event_res;
    assign m_payload_byte  = res_out.payload_byte;
    assign m_payload_index = res_out.payload_index;
    assign m_msg_type      = res_out.msg_type;
    assign m_object_id     = res_out.object_id;
    assign m_frame_length  = res_out.frame_length;
    assign m_computed_crc  = res_out.computed_crc;

`ifndef SYNTHESIS
    a_len_only_on_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_res != tfp_pkg::EV_ACCEPT && m_event_res != tfp_pkg::EV_MISMATCH
        |-> m_frame_length == 9'd0)
        else $error("frame length reported outside an end-of-frame event");

    a_accept_len_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_res == tfp_pkg::EV_ACCEPT
        |-> m_frame_length >= tfp_pkg::MIN_LEN && m_frame_length <= 9'd263)
        else $error("accepted frame has an out-of-range length");

    a_payload_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_res != tfp_pkg::EV_PAYLOAD
        |-> m_payload_byte == 8'd0 && m_payload_index == 8'd0)
        else $error("payload fields not zero outside a payload event");

    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_res == tfp_pkg::EV_PAYLOAD |-> m_payload_index != 8'd255)
        else $error("payload index beyond the longest payload");
`endif

endmodule

// ===== bench/tfp_result_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Telemetry frame parser result checker
// Watches the byte and result channels of the frame parser. For every byte
// transfer it predicts the result from its own model of the deframer, and it
// compares every result transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tfp_result_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_event_res,
    input  logic [7:0]  m_payload_byte,
    input  logic [7:0]  m_payload_index,
    input  logic [7:0]  m_msg_type,
    input  logic [31:0] m_object_id,
    input  logic [8:0]  m_frame_length,
    input  logic [7:0]  m_computed_crc,
    output int          mismatch_count,
    output int          results_pending
);

    tfp_pkg::cfg_t    cfg_q;
    tfp_pkg::phase_t  phase_q;
    logic [7:0]       crc_q;
    logic [7:0]       count_q;
    logic [7:0]       type_q;
    logic [31:0]      id_q;
    logic [15:0]      len_q;
    tfp_pkg::result_t expected_results[$];

    initial begin
        mismatch_count  = 0;
        results_pending = 0;
    end

    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] r;
        r = crc ^ data;
        repeat (8) begin
            r = r[7] ? ((r << 1) ^ tfp_pkg::CRC_POLY) : (r << 1);
        end
        return r;
    endfunction

    function automatic tfp_pkg::result_t parse_byte(input logic [7:0] b);
        tfp_pkg::result_t r;
        r = '0;
        case (phase_q)
            tfp_pkg::PH_TYPE: begin
                crc_q = crc8_next(crc_q, b);
                if ((b & cfg_q.type_mask) == cfg_q.type_version) begin
                    type_q  = b;
                    count_q = 8'd0;
                    phase_q = tfp_pkg::PH_LEN;
                end else begin
                    phase_q = tfp_pkg::PH_HUNT;
                end
            end
            tfp_pkg::PH_LEN: begin
                crc_q = crc8_next(crc_q, b);
                if (count_q == 8'd0) begin
                    len_q   = {8'd0, b};
                    count_q = 8'd1;
                end else begin
                    len_q = {b, len_q[7:0]};
                    if (len_q < {7'd0, tfp_pkg::MIN_LEN} || len_q > tfp_pkg::MAX_LEN) begin
                        phase_q = tfp_pkg::PH_HUNT;
                    end else begin
                        phase_q = tfp_pkg::PH_OBJ;
                    end
                    count_q = 8'd0;
                end
            end
            tfp_pkg::PH_OBJ: begin
                crc_q = crc8_next(crc_q, b);
                id_q[8 * count_q[1:0] +: 8] = b;
                if (count_q >= 8'd3) begin
                    count_q = 8'd0;
                    phase_q = (len_q == {7'd0, tfp_pkg::MIN_LEN}) ? tfp_pkg::PH_CRC
                                                                  : tfp_pkg::PH_DATA;
                end else begin
                    count_q = count_q + 8'd1;
                end
            end
            tfp_pkg::PH_DATA: begin
                crc_q           = crc8_next(crc_q, b);
                r.event_res     = tfp_pkg::EV_PAYLOAD;
                r.payload_byte  = b;
                r.payload_index = count_q;
                count_q         = count_q + 8'd1;
                if (count_q == 8'd0 ||
                        {8'd0, count_q} >= len_q - {7'd0, tfp_pkg::MIN_LEN}) begin
                    count_q = 8'd0;
                    phase_q = tfp_pkg::PH_CRC;
                end
            end
            tfp_pkg::PH_CRC: begin
                r.frame_length = len_q[8:0];
                r.event_res    = (b == crc_q) ? tfp_pkg::EV_ACCEPT : tfp_pkg::EV_MISMATCH;
                phase_q        = tfp_pkg::PH_HUNT;
            end
            default: begin
                phase_q = tfp_pkg::PH_HUNT;
                if (b == cfg_q.sync_value) begin
                    crc_q   = cfg_q.seed_with_sync ? crc8_next(8'd0, b) : 8'd0;
                    phase_q = tfp_pkg::PH_TYPE;
                end
            end
        endcase
        r.msg_type     = type_q;
        r.object_id    = id_q;
        r.computed_crc = crc_q;
        return r;
    endfunction

    task automatic report_error(input string msg);
        mismatch_count++;
        $display("[%0t] tfp_result_checker: %s", $time, msg);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            report_error($sformatf("%s expected %0h, got %0h", name, want, got));
        end
    endtask

    always @(posedge aclk) begin
        tfp_pkg::result_t got;
        tfp_pkg::result_t want;
        if (!aresetn) begin
            cfg_q   = '{sync_value: 8'h3C, type_mask: 8'h78, type_version: 8'h20,
                        seed_with_sync: 1'b1};
            phase_q = tfp_pkg::PH_HUNT;
            crc_q   = 8'd0;
            count_q = 8'd0;
            type_q  = 8'd0;
            id_q    = 32'd0;
            len_q   = 16'd0;
            expected_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                got = {m_event_res, m_payload_byte, m_payload_index, m_msg_type,
                       m_object_id, m_frame_length, m_computed_crc};
                if (expected_results.size() == 0) begin
                    report_error("result transfer with no byte outstanding");
                end else begin
                    want = expected_results.pop_front();
                    compare_field("event_res", 32'(want.event_res), 32'(got.event_res));
                    compare_field("payload_byte", 32'(want.payload_byte),
                                  32'(got.payload_byte));
                    compare_field("payload_index", 32'(want.payload_index),
                                  32'(got.payload_index));
                    compare_field("msg_type", 32'(want.msg_type), 32'(got.msg_type));
                    compare_field("object_id", want.object_id, got.object_id);
                    compare_field("frame_length", 32'(want.frame_length),
                                  32'(got.frame_length));
                    compare_field("computed_crc", 32'(want.computed_crc),
                                  32'(got.computed_crc));
                end
            end
            if (s_valid && s_ready) begin
                expected_results.push_back(parse_byte(s_in_byte));
            end
            if (cfg_we) begin
                case (cfg_index)
                    tfp_pkg::REG_SYNC_VALUE:     cfg_q.sync_value     = cfg_wdata;
                    tfp_pkg::REG_TYPE_MASK:      cfg_q.type_mask      = cfg_wdata;
                    tfp_pkg::REG_TYPE_VERSION:   cfg_q.type_version   = cfg_wdata;
                    tfp_pkg::REG_SEED_WITH_SYNC: cfg_q.seed_with_sync = cfg_wdata[0];
                    default: ;
                endcase
            end
        end
        results_pending <= expected_results.size();
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Telemetry frame parser testbench
// Feeds the parser a directed byte sequence and then random frames, good and
// broken, under several register settings with random idling on both sides.
// The result checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

    typedef enum {
        FRAME_GOOD,
        FRAME_BAD_CRC,
        FRAME_BAD_TYPE,
        FRAME_BAD_LEN,
        FRAME_CUT
    } frame_kind_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_in_byte;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_event_res;
    logic [7:0]  m_payload_byte;
    logic [7:0]  m_payload_index;
    logic [7:0]  m_msg_type;
    logic [31:0] m_object_id;
    logic [8:0]  m_frame_length;
    logic [7:0]  m_computed_crc;
    int          mismatch_count;
    int          results_pending;

    logic        quiet;
    int unsigned sent_count;
    logic [7:0]  sync_q;
    logic [7:0]  type_mask_q;
    logic [7:0]  type_ver_q;
    logic        seed_q;

    telemetry_frame_parser_crc8 u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_in_byte       (s_in_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_event_res     (m_event_res),
        .m_payload_byte  (m_payload_byte),
        .m_payload_index (m_payload_index),
        .m_msg_type      (m_msg_type),
        .m_object_id     (m_object_id),
        .m_frame_length  (m_frame_length),
        .m_computed_crc  (m_computed_crc)
    );

    tfp_result_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_in_byte       (s_in_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_event_res     (m_event_res),
        .m_payload_byte  (m_payload_byte),
        .m_payload_index (m_payload_index),
        .m_msg_type      (m_msg_type),
        .m_object_id     (m_object_id),
        .m_frame_length  (m_frame_length),
        .m_computed_crc  (m_computed_crc),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    always @(negedge aclk) begin
        m_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 19);
    end

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] r;
        r = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            r = r[7] ? ({r[6:0], 1'b0} ^ tfp_pkg::CRC_POLY) : {r[6:0], 1'b0};
        end
        return r;
    endfunction

    task automatic send_byte(input logic [7:0] value);
        @(negedge aclk);
        while (!quiet && $urandom_range(99) < 19) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_in_byte <= value;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        sent_count++;
    endtask

    task automatic wait_results_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (results_pending != 0) begin
            @(negedge aclk);
        end
    endtask

    task automatic program_reg(input tfp_pkg::reg_index_t idx, input logic [7:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            tfp_pkg::REG_SYNC_VALUE:     sync_q      = value;
            tfp_pkg::REG_TYPE_MASK:      type_mask_q = value;
            tfp_pkg::REG_TYPE_VERSION:   type_ver_q  = value;
            tfp_pkg::REG_SEED_WITH_SYNC: seed_q      = value[0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(input logic [7:0] sync_val, input logic [7:0] mask_val,
                              input logic [7:0] ver_val, input logic [7:0] seed_val);
        program_reg(tfp_pkg::REG_SYNC_VALUE, sync_val);
        program_reg(tfp_pkg::REG_TYPE_MASK, mask_val);
        program_reg(tfp_pkg::REG_TYPE_VERSION, ver_val);
        program_reg(tfp_pkg::REG_SEED_WITH_SYNC, seed_val);
    endtask

    // The first byte of the packet is the sync byte; the CRC covers the rest,
    // and the sync byte too when the seed register says so.
    task automatic send_packet(input logic [7:0] pkt[$], input bit add_crc, input bit corrupt);
        logic [7:0] crc;
        crc = seed_q ? crc8_update(8'h00, pkt[0]) : 8'h00;
        for (int i = 1; i < pkt.size(); i++) begin
            crc = crc8_update(crc, pkt[i]);
        end
        if (add_crc) begin
            pkt.push_back(corrupt ? (crc ^ 8'($urandom_range(1, 255))) : crc);
        end
        foreach (pkt[i]) begin
            send_byte(pkt[i]);
        end
    endtask

    task automatic send_random_frame();
        logic [7:0]  pkt[$];
        frame_kind_t kind;
        int unsigned sel;
        int unsigned len;
        int unsigned body;
        int unsigned keep;
        logic [7:0]  type_byte;
        logic [31:0] obj;
        sel = $urandom_range(99);
        if (sel < 70) begin
            kind = FRAME_GOOD;
        end else if (sel < 80) begin
            kind = FRAME_BAD_CRC;
        end else if (sel < 87) begin
            kind = FRAME_BAD_TYPE;
        end else if (sel < 94) begin
            kind = FRAME_BAD_LEN;
        end else begin
            kind = FRAME_CUT;
        end
        sel = $urandom_range(99);
        if (sel < 2) begin
            len = 32'(tfp_pkg::MAX_LEN);
        end else if (sel < 10) begin
            len = $urandom_range(25, 262);
        end else begin
            len = $urandom_range(8, 24);
        end
        if (kind == FRAME_BAD_LEN) begin
            case ($urandom_range(3))
                0: len = $urandom_range(0, 7);
                1: len = 32'(tfp_pkg::MAX_LEN) + 1;
                2: len = $urandom_range(265, 65535);
                default: len = 65535;
            endcase
        end
        type_byte = (type_ver_q & type_mask_q) | (8'($urandom) & ~type_mask_q);
        if (kind == FRAME_BAD_TYPE) begin
            repeat (8) begin
                if ((type_byte & type_mask_q) == type_ver_q) begin
                    type_byte = 8'($urandom);
                end
            end
        end
        obj = $urandom;
        pkt.push_back(sync_q);
        pkt.push_back(type_byte);
        pkt.push_back(len[7:0]);
        pkt.push_back(len[15:8]);
        for (int i = 0; i < 4; i++) begin
            pkt.push_back(obj[8 * i +: 8]);
        end
        body = (kind == FRAME_BAD_LEN) ? $urandom_range(0, 4) : len - 8;
        repeat (body) begin
            pkt.push_back(($urandom_range(9) == 0) ? sync_q : 8'($urandom));
        end
        if (kind == FRAME_CUT) begin
            keep = $urandom_range(1, pkt.size() - 1);
            while (pkt.size() > keep) begin
                pkt.delete(pkt.size() - 1);
            end
        end
        send_packet(pkt, kind == FRAME_GOOD || kind == FRAME_BAD_CRC, kind == FRAME_BAD_CRC);
        if ($urandom_range(4) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                send_byte(8'($urandom));
            end
        end
    endtask

    initial begin
        logic [7:0]  pkt[$];
        logic [7:0]  mask_pick;
        int unsigned stop_at;
        aresetn     = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = tfp_pkg::REG_SYNC_VALUE;
        cfg_wdata   = 8'h00;
        s_valid     = 1'b0;
        s_in_byte   = 8'h00;
        quiet       = 1'b0;
        sent_count  = 0;
        sync_q      = 8'h3C;
        type_mask_q = 8'h78;
        type_ver_q  = 8'h20;
        seed_q      = 1'b1;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part under the reset settings: noise while hunting, a bad
        // type, a bad length, a frame with no payload, and a payload that holds
        // the sync value followed by a wrong CRC.
        send_byte(8'h00);
        send_byte(sync_q);
        send_byte(8'h87);
        send_byte(sync_q);
        send_byte(8'hA7);
        send_byte(8'h07);
        send_byte(8'h00);
        pkt = '{sync_q, 8'hA7, 8'h08, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_packet(pkt, 1'b1, 1'b0);
        pkt = '{sync_q, 8'h20, 8'h09, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, sync_q};
        send_packet(pkt, 1'b1, 1'b1);

        for (int phase = 0; phase < 5; phase++) begin
            wait_results_drained();
            case (phase)
                1: set_config(8'h00, 8'hFF, 8'hFF, 8'h00);
                2: set_config(8'hFF, 8'h00, 8'h00, 8'h01);
                3: begin
                    mask_pick = 8'($urandom);
                    set_config(8'($urandom), mask_pick, 8'($urandom) & mask_pick,
                               8'($urandom));
                end
                4: begin
                    mask_pick = 8'($urandom);
                    set_config(8'($urandom), mask_pick,
                               ($urandom_range(3) == 0) ? 8'($urandom)
                                                        : (8'($urandom) & mask_pick),
                               8'($urandom));
                end
                default: ;
            endcase
            quiet   = (phase == 3);
            stop_at = sent_count + 350;
            while (sent_count < stop_at) begin
                send_random_frame();
            end
        end

        wait_results_drained();
        repeat (4) @(negedge aclk);
        if (mismatch_count == 0 && results_pending == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule
